// ===== rtl/vgtl_pkg.sv =====
// ----------------------------------------------------------------------------
// vgtl_pkg
// Shared widths, defaults and codes for the voxel grid trilinear lookup.
// ----------------------------------------------------------------------------
package vgtl_pkg;

  localparam int DATA_W   = 32;
  localparam int INV_W    = 31;
  localparam int CELL_W   = 5;
  localparam int NUM_CH   = 4;
  localparam int CFG_IDX_W = 3;

  localparam int GRID_X_DEF    = 32;
  localparam int GRID_Y_DEF    = 32;
  localparam int GRID_Z_DEF    = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_INV_STEP_X = 3'd3,
    CFG_INV_STEP_Y = 3'd4,
    CFG_INV_STEP_Z = 3'd5
  } cfg_reg_e;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

// ===== rtl/vgtl_if.sv =====
// ----------------------------------------------------------------------------
// vgtl request and response interfaces
// Valid/ready channels carrying load/query requests and lookup results.
// ----------------------------------------------------------------------------
interface vgtl_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [4:0]         cell_x;
  logic [4:0]         cell_y;
  logic [4:0]         cell_z;
  logic signed [31:0] pen_value;
  logic signed [31:0] gradx_value;
  logic signed [31:0] grady_value;
  logic signed [31:0] gradz_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, req_type, cell_x, cell_y, cell_z, pen_value, gradx_value,
                  grady_value, gradz_value, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, req_type, cell_x, cell_y, cell_z, pen_value, gradx_value,
                grady_value, gradz_value, pos_x, pos_y, pos_z, output ready);
endinterface

interface vgtl_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] penalty_out;
  logic signed [31:0] grad_x_out;
  logic signed [31:0] grad_y_out;
  logic signed [31:0] grad_z_out;
  logic               inside_res;

  modport source (output valid, penalty_out, grad_x_out, grad_y_out, grad_z_out, inside_res,
                  input ready);
  modport sink (input valid, penalty_out, grad_x_out, grad_y_out, grad_z_out, inside_res,
                output ready);
endinterface

// ===== rtl/voxel_grid_trilinear_lookup_top.sv =====
// A query result passes axis mapping, bank read and the x, y and z blends before output.
// Throughput: one transaction (load or query) per cycle, stalls only on output backpressure.
// Loads are written to the grid banks on the same enable as the bank read, ahead of any later query read.
// Reset zeroes valids and origins, inverse steps become 1.0; grid undefined until loaded.
// ----------------------------------------------------------------------------
// voxel_grid_trilinear_lookup_top
// Eight parity-banked grid memories feeding a 7-stage trilinear lookup pipeline.
// ----------------------------------------------------------------------------
module voxel_grid_trilinear_lookup_top import vgtl_pkg::*; #(
  parameter int GRID_X    = GRID_X_DEF,
  parameter int GRID_Y    = GRID_Y_DEF,
  parameter int GRID_Z    = GRID_Z_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  vgtl_req_if.sink             req_i,
  vgtl_rsp_if.source           rsp_o
);

  localparam int XW  = $clog2(GRID_X);
  localparam int YW  = $clog2(GRID_Y);
  localparam int ZW  = $clog2(GRID_Z);
  localparam int XHW = (XW > 1) ? XW - 1 : 1;
  localparam int YHW = (YW > 1) ? YW - 1 : 1;
  localparam int ZHW = (ZW > 1) ? ZW - 1 : 1;
  localparam int AW  = XHW + YHW + ZHW;
  localparam int MW  = NUM_CH * DATA_W;

  typedef struct packed {
    logic          query;
    logic          wr_ok;
    logic [2:0]    bank;
    logic [AW-1:0] addr;
    logic [MW-1:0] data;
  } ld_item_t;

  // configuration
  logic signed [DATA_W-1:0] origin_q [3];
  logic [INV_W-1:0]         inv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        origin_q[a] <= '0;
        inv_q[a]    <= INV_W'(1) << FRAC_BITS;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X:   origin_q[0] <= cfg_wdata_i;
        CFG_ORIGIN_Y:   origin_q[1] <= cfg_wdata_i;
        CFG_ORIGIN_Z:   origin_q[2] <= cfg_wdata_i;
        CFG_INV_STEP_X: inv_q[0]    <= cfg_wdata_i[INV_W-1:0];
        CFG_INV_STEP_Y: inv_q[1]    <= cfg_wdata_i[INV_W-1:0];
        CFG_INV_STEP_Z: inv_q[2]    <= cfg_wdata_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage loads when empty or when the next one loads
  logic [7:1] v_q;
  logic [8:1] ld;

  always_comb begin
    ld[8] = rsp_o.ready;
    ld[7] = !v_q[7] || rsp_o.ready;
    for (int k = 6; k >= 1; k--) ld[k] = !v_q[k] || ld[k+1];
  end

  assign req_i.ready = ld[1];

  // load payload at entry
  logic [XW-1:0] lx;
  logic [YW-1:0] ly;
  logic [ZW-1:0] lz;
  ld_item_t      ld_d;
  ld_item_t      ld_q [3];
  logic          v4_d;

  assign lx = XW'(req_i.cell_x);
  assign ly = YW'(req_i.cell_y);
  assign lz = ZW'(req_i.cell_z);

  always_comb begin
    ld_d.query = (req_i.req_type == REQ_QUERY);
    ld_d.wr_ok = (32'(req_i.cell_x) < 32'(GRID_X)) && (32'(req_i.cell_y) < 32'(GRID_Y))
              && (32'(req_i.cell_z) < 32'(GRID_Z));
    ld_d.bank  = {lx[0], ly[0], lz[0]};
    ld_d.addr  = {XHW'(lx >> 1), YHW'(ly >> 1), ZHW'(lz >> 1)};
    ld_d.data  = {req_i.gradz_value, req_i.grady_value, req_i.gradx_value, req_i.pen_value};
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) ld_q[0] <= ld_d;
    if (ld[2]) ld_q[1] <= ld_q[0];
    if (ld[3]) ld_q[2] <= ld_q[1];
  end

  assign v4_d = v_q[3] && ld_q[2].query;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[1]) v_q[1] <= req_i.valid;
      if (ld[2]) v_q[2] <= v_q[1];
      if (ld[3]) v_q[3] <= v_q[2];
      if (ld[4]) v_q[4] <= v4_d;
      if (ld[5]) v_q[5] <= v_q[4];
      if (ld[6]) v_q[6] <= v_q[5];
      if (ld[7]) v_q[7] <= v_q[6];
    end
  end

  // coordinate mapping, stages 1 to 3
  logic [XW-1:0]        ix;
  logic [YW-1:0]        iy;
  logic [ZW-1:0]        iz;
  logic [FRAC_BITS-1:0] fr [3];
  logic [2:0]           ok;

  vgtl_axis #(.SIZE(GRID_X), .FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk_i, .en_i(ld[3:1]), .pos_i(req_i.pos_x), .org_i(origin_q[0]), .inv_i(inv_q[0]),
    .idx_o(ix), .frac_o(fr[0]), .ok_o(ok[0]));
  vgtl_axis #(.SIZE(GRID_Y), .FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk_i, .en_i(ld[3:1]), .pos_i(req_i.pos_y), .org_i(origin_q[1]), .inv_i(inv_q[1]),
    .idx_o(iy), .frac_o(fr[1]), .ok_o(ok[1]));
  vgtl_axis #(.SIZE(GRID_Z), .FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk_i, .en_i(ld[3:1]), .pos_i(req_i.pos_z), .org_i(origin_q[2]), .inv_i(inv_q[2]),
    .idx_o(iz), .frac_o(fr[2]), .ok_o(ok[2]));

  // parity banks: corner (x+dx) lands in bank parity (x+dx)&1 per axis
  logic [MW-1:0] rd [8];
  logic [2:0]    par4_q;
  logic [FRAC_BITS-1:0] fx4_q, fy4_q, fz4_q;
  logic          ins4_q;

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic PX = 1'((b >> 2) & 1);
    localparam logic PY = 1'((b >> 1) & 1);
    localparam logic PZ = 1'(b & 1);
    logic [XW-1:0] xc;
    logic [YW-1:0] yc;
    logic [ZW-1:0] zc;
    logic [AW-1:0] raddr;
    logic          we;

    assign xc    = ix + XW'(ix[0] ^ PX);
    assign yc    = iy + YW'(iy[0] ^ PY);
    assign zc    = iz + ZW'(iz[0] ^ PZ);
    assign raddr = {XHW'(xc >> 1), YHW'(yc >> 1), ZHW'(zc >> 1)};
    assign we    = ld[4] && v_q[3] && !ld_q[2].query && ld_q[2].wr_ok
                && (ld_q[2].bank == 3'(b));

    vgtl_bank #(.AW(AW), .DW(MW)) u_bank (
      .clk_i, .we_i(we), .waddr_i(ld_q[2].addr), .wdata_i(ld_q[2].data),
      .re_i(ld[4]), .raddr_i(raddr), .rdata_o(rd[b]));
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      par4_q <= {ix[0], iy[0], iz[0]};
      fx4_q  <= fr[0];
      fy4_q  <= fr[1];
      fz4_q  <= fr[2];
      ins4_q <= &ok;
    end
  end

  // x blend: lane ch*4 + dy*2 + dz
  logic signed [DATA_W-1:0] xa [16];
  logic signed [DATA_W-1:0] xb [16];
  logic signed [DATA_W-1:0] c5 [16];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int yz = 0; yz < 4; yz++) begin
        xa[ch*4+yz] = rd[3'(yz) ^ par4_q][ch*DATA_W +: DATA_W];
        xb[ch*4+yz] = rd[(3'(yz) | 3'b100) ^ par4_q][ch*DATA_W +: DATA_W];
      end
    end
  end

  vgtl_lerp_stage #(.LANES(16), .FRAC_BITS(FRAC_BITS)) u_lerp_x (
    .clk_i, .en_i(ld[5]), .a_i(xa), .b_i(xb), .f_i(fx4_q), .y_o(c5));

  logic [FRAC_BITS-1:0] fy5_q, fz5_q, fz6_q;
  logic                 ins5_q, ins6_q, ins7_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      fy5_q  <= fy4_q;
      fz5_q  <= fz4_q;
      ins5_q <= ins4_q;
    end
    if (ld[6]) begin
      fz6_q  <= fz5_q;
      ins6_q <= ins5_q;
    end
    if (ld[7]) ins7_q <= ins6_q;
  end

  // y blend: lane ch*2 + dz
  logic signed [DATA_W-1:0] ya [8];
  logic signed [DATA_W-1:0] yb [8];
  logic signed [DATA_W-1:0] c6 [8];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int dz = 0; dz < 2; dz++) begin
        ya[ch*2+dz] = c5[ch*4+dz];
        yb[ch*2+dz] = c5[ch*4+2+dz];
      end
    end
  end

  vgtl_lerp_stage #(.LANES(8), .FRAC_BITS(FRAC_BITS)) u_lerp_y (
    .clk_i, .en_i(ld[6]), .a_i(ya), .b_i(yb), .f_i(fy5_q), .y_o(c6));

  // z blend: lane ch
  logic signed [DATA_W-1:0] za [4];
  logic signed [DATA_W-1:0] zb [4];
  logic signed [DATA_W-1:0] c7 [4];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      za[ch] = c6[ch*2];
      zb[ch] = c6[ch*2+1];
    end
  end

  vgtl_lerp_stage #(.LANES(4), .FRAC_BITS(FRAC_BITS)) u_lerp_z (
    .clk_i, .en_i(ld[7]), .a_i(za), .b_i(zb), .f_i(fz6_q), .y_o(c7));

  // outside queries report zeros
  assign rsp_o.valid       = v_q[7];
  assign rsp_o.inside_res  = ins7_q;
  assign rsp_o.penalty_out = ins7_q ? c7[0] : '0;
  assign rsp_o.grad_x_out  = ins7_q ? c7[1] : '0;
  assign rsp_o.grad_y_out  = ins7_q ? c7[2] : '0;
  assign rsp_o.grad_z_out  = ins7_q ? c7[3] : '0;

endmodule

// ===== rtl/vgtl_axis.sv =====
// ----------------------------------------------------------------------------
// vgtl_axis
// Three-stage world-to-grid mapping of one axis: offset, scale, split/check.
// ----------------------------------------------------------------------------
module vgtl_axis import vgtl_pkg::*; #(
  parameter int SIZE      = GRID_X_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IW       = $clog2(SIZE)
) (
  input  logic                     clk_i,
  input  logic [2:0]               en_i,
  input  logic signed [DATA_W-1:0] pos_i,
  input  logic signed [DATA_W-1:0] org_i,
  input  logic [INV_W-1:0]         inv_i,
  output logic [IW-1:0]            idx_o,
  output logic [FRAC_BITS-1:0]     frac_o,
  output logic                     ok_o
);

  localparam int PW  = 64;
  localparam int IPW = PW - 2 * FRAC_BITS;

  logic signed [DATA_W:0]   d_q, d_d;
  logic signed [PW:0]       prod;
  logic signed [PW-1:0]     p_q;
  logic [IPW-1:0]           ip;
  logic                     ok_d;

  assign d_d  = $signed({pos_i[DATA_W-1], pos_i}) - $signed({org_i[DATA_W-1], org_i});
  assign prod = d_q * $signed({1'b0, inv_i});
  assign ip   = p_q[PW-1:2*FRAC_BITS];
  // positive coordinate whose integer part leaves room for the upper corner
  assign ok_d = !p_q[PW-1] && (p_q != '0) && (ip < IPW'(SIZE - 1));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) d_q <= d_d;
    if (en_i[1]) p_q <= prod[PW-1:0];
    if (en_i[2]) begin
      idx_o  <= ip[IW-1:0];
      frac_o <= p_q[2*FRAC_BITS-1:FRAC_BITS];
      ok_o   <= ok_d;
    end
  end

endmodule

// ===== rtl/vgtl_bank.sv =====
// ----------------------------------------------------------------------------
// vgtl_bank
// One parity bank of the grid: single write port, registered read port.
// ----------------------------------------------------------------------------
module vgtl_bank #(
  parameter int AW = 12,
  parameter int DW = 128
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/vgtl_lerp_stage.sv =====
// ----------------------------------------------------------------------------
// vgtl_lerp_stage
// Registered linear blend of several lanes with a shared weight, half-up round.
// ----------------------------------------------------------------------------
module vgtl_lerp_stage import vgtl_pkg::*; #(
  parameter int LANES     = 4,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] a_i [LANES],
  input  logic signed [DATA_W-1:0] b_i [LANES],
  input  logic [FRAC_BITS-1:0]     f_i,
  output logic signed [DATA_W-1:0] y_o [LANES]
);

  localparam int VW = FRAC_BITS + DATA_W + 3;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [DATA_W:0]           diff;
    logic signed [DATA_W+FRAC_BITS+1:0] prod;
    logic signed [VW-1:0]             acc;

    // a*(1-f) + b*f == a + (b-a)*f
    assign diff = $signed({b_i[l][DATA_W-1], b_i[l]}) - $signed({a_i[l][DATA_W-1], a_i[l]});
    assign prod = diff * $signed({1'b0, f_i});
    assign acc  = (VW'(a_i[l]) <<< FRAC_BITS) + VW'(prod)
                + (VW'(1) <<< (FRAC_BITS - 1));

    always_ff @(posedge clk_i) begin
      if (en_i) y_o[l] <= acc[FRAC_BITS+DATA_W-1:FRAC_BITS];
    end
  end

endmodule
